// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file bsi_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/bsi_pkg.sv =====
// Package for the bit-vector seek iterator: widths, codes, FSM and link types.
// No dependencies.
`default_nettype none

package bsi_pkg;

    localparam int DEF_MAX_DOCS  = 65536;
    localparam int DEF_WORD_BITS = 64;

    localparam int DOC_W    = 17;
    localparam int DOC_MAX  = 2 ** DOC_W - 1;
    localparam int WIDX_W   = 10;
    localparam int IDX_SPAN = 2 ** WIDX_W;
    localparam int DATA_W   = 64;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEEK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DOC_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERTED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRICT    = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PRIME,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic clr_en;
        logic wr_en;
        logic div_load;
        logic prime;
        logic scan_step;
        logic res_end;
        logic res_hit;
        logic res_init;
        logic res_miss;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic target_past;
        logic strict;
        logic eval_hit;
        logic eval_end;
        logic eval_miss;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== sv/bitvector_seek_iterator_core.sv =====
// Top level of the bit-vector seek iterator: sequencer plus datapath.
// Depends on bsi_pkg, bsi_ctrl, bsi_datapath.
//
// After reset the bit store is swept to zero, one word a cycle, over all
// min(ceil(MAX_DOCS/WORD_BITS), 1024) words (1024 at the default size) with
// o_busy high; config writes are taken throughout and o_cfg_ready is always
// high. A word write gives no result. An init range in non-strict mode, or
// any seek/init whose target is at or beyond the limit, gives its result in
// the cycle after acceptance. Other seeks and strict init ranges compute the
// target's word index by a reciprocal multiplication at acceptance, then pass
// through a priming state that starts the store read and sets the bit offset,
// then scan one store word a cycle through the single read port, examining
// one word in non-strict mode and up to about 1025 in strict mode; o_busy is
// low again in the result cycle.
// Each result is flagged by o_done for exactly one cycle; the receiver cannot
// stall it.
`default_nettype none

module bitvector_seek_iterator_core
    import bsi_pkg::*;
#(
    parameter int MAX_DOCS  = DEF_MAX_DOCS,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic [CMD_W-1:0]     i_command,
    input  wire logic [WIDX_W-1:0]    i_word_index,
    input  wire logic [DATA_W-1:0]    i_word_data,
    input  wire logic [DOC_W-1:0]     i_target_doc,
    output logic                      o_done,
    output logic [DOC_W-1:0]          o_current_doc,
    output logic                      o_at_end,
    output logic                      o_landed,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DOC_W-1:0]     i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    bsi_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_command (i_command),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd),
        .o_busy    (o_busy)
    );

    bsi_datapath #(
        .MAX_DOCS  (MAX_DOCS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_word_index  (i_word_index),
        .i_word_data   (i_word_data),
        .i_target_doc  (i_target_doc),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_current_doc (o_current_doc),
        .o_at_end      (o_at_end),
        .o_landed      (o_landed),
        .o_done        (o_done)
    );

endmodule

`default_nettype wire

// ===== sv/bsi_ctrl.sv =====
// Sequencer for the seek iterator: clearing pass, division, word scan, results.
// Depends on bsi_pkg.
`default_nettype none

module bsi_ctrl
    import bsi_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [CMD_W-1:0] i_command,
    input  wire t_dp_stat         i_stat,
    output t_dp_cmd               o_cmd,
    output logic                  o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != ST_IDLE);
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_command)
                        CMD_WRITE: begin
                            o_cmd.wr_en = 1'b1;
                        end
                        CMD_INIT, CMD_SEEK: begin
                            priority if (i_stat.target_past) begin
                                o_cmd.res_end = 1'b1;
                            end else if (i_command == CMD_INIT && !i_stat.strict) begin
                                o_cmd.res_init = 1'b1;
                            end else begin
                                o_cmd.div_load = 1'b1;
                                n_state        = ST_PRIME;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PRIME: begin
                o_cmd.prime = 1'b1;
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                priority if (i_stat.eval_hit) begin
                    o_cmd.res_hit = 1'b1;
                    n_state       = ST_IDLE;
                end else if (i_stat.eval_end) begin
                    o_cmd.res_end = 1'b1;
                    n_state       = ST_IDLE;
                end else if (i_stat.eval_miss) begin
                    o_cmd.res_miss = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/bsi_datapath.sv =====
// Datapath: bit store, config registers, target divider, word scan, result registers.
// Depends on bsi_pkg.
`default_nettype none

module bsi_datapath
    import bsi_pkg::*;
#(
    parameter int MAX_DOCS  = DEF_MAX_DOCS,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    input  wire logic [WIDX_W-1:0]    i_word_index,
    input  wire logic [DATA_W-1:0]    i_word_data,
    input  wire logic [DOC_W-1:0]     i_target_doc,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DOC_W-1:0]     i_cfg_data,
    output logic [DOC_W-1:0]          o_current_doc,
    output logic                      o_at_end,
    output logic                      o_landed,
    output logic                      o_done
);

    localparam int STORE_WORDS = (MAX_DOCS + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH   = STORE_WORDS < IDX_SPAN ? STORE_WORDS : IDX_SPAN;
    localparam int AW      = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int BW      = $clog2(WORD_BITS);
    localparam int LIM_CAP = MAX_DOCS < DOC_MAX ? MAX_DOCS : DOC_MAX;
    localparam int RECIP_SH = DOC_W + BW;
    localparam int RECIP    = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W   = 2 * DOC_W + 2;

    logic [WORD_BITS-1:0] mem [0:DEPTH-1];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_in_q;
    logic [AW-1:0]        r_clr_addr;

    logic [DOC_W-1:0] r_doc_limit;
    logic             r_inv;
    logic             r_strict;

    logic [DOC_W-1:0]     r_quo;
    logic [DOC_W-1:0]     r_target;
    logic [DOC_W:0]       r_base;
    logic [BW-1:0]        r_bit;
    logic                 r_first;

    logic [DOC_W-1:0] r_pos;
    logic             r_end;
    logic             r_landed;
    logic             r_done;

    logic [DOC_W-1:0]     lim;
    logic                 wr_ok;
    logic [PROD_W-1:0]    quo_prod;
    logic [DOC_W-1:0]     div_quo;
    logic [DOC_W-1:0]     q_base;
    logic [WORD_BITS-1:0] word_q;
    logic [WORD_BITS-1:0] word_adj;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] hits;
    logic [WORD_BITS-1:0] lowest;
    logic [BW-1:0]        idx;
    logic [DOC_W:0]       hit_doc;
    logic                 any_hit;
    logic                 base_past;

    assign lim   = (r_doc_limit < DOC_W'(LIM_CAP)) ? r_doc_limit : DOC_W'(LIM_CAP);
    assign wr_ok = {1'b0, i_word_index} < (WIDX_W + 1)'(DEPTH);

    // bit store: clearing sweep, word writes, registered read at the scan pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr_en && wr_ok) begin
            mem[i_word_index[AW-1:0]] <= i_word_data[WORD_BITS-1:0];
        end
        r_rdata <= mem[r_quo[AW-1:0]];
        r_in_q  <= r_quo < DOC_W'(DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doc_limit <= DOC_W'(65536);
            r_inv       <= 1'b0;
            r_strict    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DOC_LIMIT: r_doc_limit <= i_cfg_data;
                CFG_INVERTED:  r_inv       <= i_cfg_data[0];
                CFG_STRICT:    r_strict    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // word index of the target by reciprocal multiplication, exact over 17 bits
    assign quo_prod = PROD_W'(i_target_doc) * PROD_W'(RECIP);
    assign div_quo  = DOC_W'(quo_prod >> RECIP_SH);
    assign q_base   = r_quo * DOC_W'(WORD_BITS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_quo    <= div_quo;
            r_target <= i_target_doc;
        end else if (i_cmd.prime) begin
            r_quo   <= r_quo + DOC_W'(1);
            r_base  <= {1'b0, q_base};
            r_bit   <= BW'(r_target - q_base);
            r_first <= 1'b1;
        end else if (i_cmd.scan_step) begin
            r_quo   <= r_quo + DOC_W'(1);
            r_base  <= r_base + (DOC_W + 1)'(WORD_BITS);
            r_first <= 1'b0;
        end
    end

    // one word evaluated per cycle
    always_comb begin
        word_q   = r_in_q ? r_rdata : '0;
        word_adj = r_inv ? ~word_q : word_q;
        if (!r_first) begin
            mask = '1;
        end else if (r_strict) begin
            mask = {WORD_BITS{1'b1}} << r_bit;
        end else begin
            mask = WORD_BITS'(1) << r_bit;
        end
        hits   = word_adj & mask;
        lowest = hits & (~hits + WORD_BITS'(1));
        idx    = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (lowest[i]) begin
                idx = idx | BW'(i);
            end
        end
        any_hit   = |hits;
        hit_doc   = r_base + (DOC_W + 1)'(idx);
        base_past = r_base >= {1'b0, lim};
    end

    always_comb begin
        o_stat.clear_last  = r_clr_addr == AW'(DEPTH - 1);
        o_stat.target_past = i_target_doc >= lim;
        o_stat.strict      = r_strict;
        o_stat.eval_hit    = !base_past && any_hit && (hit_doc < {1'b0, lim});
        o_stat.eval_end    = base_past || (any_hit && (hit_doc >= {1'b0, lim}));
        o_stat.eval_miss   = !base_past && !any_hit && !r_strict;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_end    <= 1'b0;
            r_landed <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_cmd.res_end | i_cmd.res_hit | i_cmd.res_init | i_cmd.res_miss;
            if (i_cmd.res_end) begin
                r_pos    <= lim;
                r_end    <= 1'b1;
                r_landed <= 1'b0;
            end else if (i_cmd.res_hit) begin
                r_pos    <= hit_doc[DOC_W-1:0];
                r_end    <= 1'b0;
                r_landed <= 1'b1;
            end else if (i_cmd.res_init) begin
                r_pos    <= (i_target_doc == '0) ? '0 : i_target_doc - DOC_W'(1);
                r_end    <= 1'b0;
                r_landed <= 1'b0;
            end else if (i_cmd.res_miss) begin
                r_landed <= 1'b0;
            end
        end
    end

    assign o_current_doc = r_pos;
    assign o_at_end      = r_end;
    assign o_landed      = r_landed;
    assign o_done        = r_done;

endmodule

`default_nettype wire

// ===== sv/bsi_checker.sv =====
// Port-level checks for the seek iterator, bound to the top level.
// Depends on bsi_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module bsi_checker
    import bsi_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_start,
    input wire logic [CMD_W-1:0] i_command,
    input wire logic             o_busy,
    input wire logic             o_done,
    input wire logic             o_at_end,
    input wire logic             o_landed
);

    logic take;
    logic take_write;
    logic take_move;

    assign take       = i_start && !o_busy;
    assign take_write = take && (i_command == CMD_WRITE);
    assign take_move  = take && ((i_command == CMD_INIT) || (i_command == CMD_SEEK));

    `ASSERT_IMPL(a_end_not_landed, i_clk, i_rst_n, o_done && o_at_end, !o_landed)
    `ASSERT_NEXT(a_write_no_word, i_clk, i_rst_n, take_write, !o_done)
    `ASSERT_NEXT(a_move_answers, i_clk, i_rst_n, take_move, o_done || o_busy)
    `ASSERT_IMPL(a_done_when_idle, i_clk, i_rst_n, o_done, !o_busy || $past(!o_busy))

endmodule

bind bitvector_seek_iterator_core bsi_checker u_bsi_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (i_start),
    .i_command (i_command),
    .o_busy    (o_busy),
    .o_done    (o_done),
    .o_at_end  (o_at_end),
    .o_landed  (o_landed)
);

`default_nettype wire
